[hw/rtl/altc_pkg.sv]
`timescale 1ns / 1ps
package altc_pkg;

    localparam int KW_W        = 64;
    localparam int CH_W        = 8;
    localparam int IDX_W       = 5;
    localparam int OPC_COUNT_W = 6;
    localparam int DIR_COUNT_W = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int TOKCNT_W    = 4;
    localparam int SUM_TOK_W   = 5;

    localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_COMMA = 8'h2C;

    localparam logic [CFG_IDX_W-1:0] CFG_OPCODE_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTIVE_COUNT = 2'd1;

    typedef enum logic {
        ACT_CHAR  = 1'b0,
        ACT_WRITE = 1'b1
    } t_action;

    typedef enum logic {
        TSEL_OPCODE    = 1'b0,
        TSEL_DIRECTIVE = 1'b1
    } t_table_sel;

    typedef enum logic [2:0] {
        LC_EMPTY       = 3'd0,
        LC_OPCODE      = 3'd1,
        LC_DIRECTIVE   = 3'd2,
        LC_LABEL_OP    = 3'd3,
        LC_LABEL_DIR   = 3'd4,
        LC_LONE_LABEL  = 3'd5,
        LC_INVALID     = 3'd6,
        LC_OVERFLOW    = 3'd7
    } t_line_class;

    typedef enum logic [2:0] {
        M_IDLE,
        M_OP1,
        M_DIR1,
        M_OP2,
        M_DIR2,
        M_DONE
    } t_mstate;

    typedef struct packed {
        logic [SUM_TOK_W-1:0] tokens;
        logic                 overflow;
        logic [1:0]           too_long;
        logic [KW_W-1:0]      text0;
        logic [KW_W-1:0]      text1;
    } t_line_sum;

    typedef struct packed {
        logic             en;
        t_table_sel       sel;
        logic [IDX_W-1:0] idx;
        logic [KW_W-1:0]  keyword;
    } t_kw_write;

    typedef struct packed {
        logic                  en;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_write;

endpackage

[hw/rtl/altc_if.sv]
`timescale 1ns / 1ps
interface altc_item_if;
    logic                         valid;
    logic                         ready;
    logic                         action;
    logic [altc_pkg::CH_W-1:0]    ch;
    logic                         table_select;
    logic [altc_pkg::IDX_W-1:0]   entry_index;
    logic [altc_pkg::KW_W-1:0]    keyword;

    modport source (output valid, action, ch, table_select, entry_index, keyword,
                    input ready);
    modport sink   (input valid, action, ch, table_select, entry_index, keyword,
                    output ready);
endinterface

interface altc_result_if;
    logic                           valid;
    logic                           ready;
    logic [altc_pkg::TOKCNT_W-1:0]  tok_total;
    logic [2:0]                     line_class;

    modport source (output valid, tok_total, line_class, input ready);
    modport sink   (input valid, tok_total, line_class, output ready);
endinterface

interface altc_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [altc_pkg::CFG_IDX_W-1:0]    index;
    logic [altc_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/asm_line_token_classifier.sv]
`timescale 1ns / 1ps
// Line characters and table writes: one transfer per cycle while the input is ready, no result.
// Line end: the first token is looked up in the opcode table and then the directive table,
// and with two or more tokens the second token the same way, until a hit; each table walk is
// bounded by its configured count; one 64-bit comparator walks the tables, then the result loads.
// The input is not ready during that walk, nor while a finished line waits on a held result.
// Synchronous active-low reset clears line state, counts and the result valid flag.
module asm_line_token_classifier #(
    parameter int MAX_TOKENS        = 10,
    parameter int MAX_TOKEN_CHARS   = 49,
    parameter int KEYWORD_CHARS     = 8,
    parameter int OPCODE_ENTRIES    = 32,
    parameter int DIRECTIVE_ENTRIES = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    altc_item_if.sink     i_item,
    altc_cfg_if.sink      i_cfg,
    altc_result_if.source o_result
);
    import altc_pkg::*;

    logic       w_idle, w_acc, w_char, w_end;
    t_line_sum  w_sum;
    t_kw_write  w_wr;
    t_cfg_write w_cfg;

    assign i_item.ready = w_idle;
    assign w_acc  = i_item.valid && w_idle;
    assign w_char = w_acc && (i_item.action == ACT_CHAR);
    assign w_end  = w_char && (i_item.ch == CH_NUL);

    assign w_wr.en      = w_acc && (i_item.action == ACT_WRITE);
    assign w_wr.sel     = t_table_sel'(i_item.table_select);
    assign w_wr.idx     = i_item.entry_index;
    assign w_wr.keyword = i_item.keyword;

    assign i_cfg.ready = 1'b1;
    assign w_cfg.en    = i_cfg.valid;
    assign w_cfg.index = i_cfg.index;
    assign w_cfg.data  = i_cfg.data;

    altc_scanner #(
        .MAX_TOKENS      (MAX_TOKENS),
        .MAX_TOKEN_CHARS (MAX_TOKEN_CHARS),
        .KEYWORD_CHARS   (KEYWORD_CHARS)
    ) u_scanner (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_char_valid (w_char),
        .i_ch         (i_item.ch),
        .o_sum        (w_sum)
    );

    altc_matcher #(
        .KEYWORD_CHARS     (KEYWORD_CHARS),
        .OPCODE_ENTRIES    (OPCODE_ENTRIES),
        .DIRECTIVE_ENTRIES (DIRECTIVE_ENTRIES)
    ) u_matcher (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (w_end),
        .i_sum         (w_sum),
        .i_wr          (w_wr),
        .i_cfg         (w_cfg),
        .i_out_ready   (o_result.ready),
        .o_idle        (w_idle),
        .o_out_valid   (o_result.valid),
        .o_tok_total   (o_result.tok_total),
        .o_line_class  (o_result.line_class)
    );

endmodule

[hw/rtl/altc_scanner.sv]
`timescale 1ns / 1ps
module altc_scanner #(
    parameter int MAX_TOKENS      = 10,
    parameter int MAX_TOKEN_CHARS = 49,
    parameter int KEYWORD_CHARS   = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_char_valid,
    input  logic [altc_pkg::CH_W-1:0]   i_ch,
    output altc_pkg::t_line_sum         o_sum
);
    import altc_pkg::*;

    localparam int TW = $clog2(MAX_TOKENS + 1);
    localparam int CW = $clog2(MAX_TOKEN_CHARS + 1);
    localparam logic [TW-1:0] TOK_MAX = TW'(MAX_TOKENS);
    localparam logic [CW-1:0] CHR_MAX = CW'(MAX_TOKEN_CHARS);
    localparam logic [CW-1:0] KW_LEN  = CW'(KEYWORD_CHARS);

    logic [TW-1:0]   r_tokens, n_tokens;
    logic [CW-1:0]   r_chars, n_chars;
    logic            r_inside, n_inside;
    logic [KW_W-1:0] r_text0, n_text0;
    logic [KW_W-1:0] r_text1, n_text1;
    logic [1:0]      r_long, n_long;
    logic            r_ovf, n_ovf;

    logic [CW-1:0]   w_chars_eff;
    logic [TW-1:0]   w_tok_final;
    logic            w_sep;

    assign w_sep = (i_ch == CH_SPACE) || (i_ch == CH_COMMA);

    always_comb begin
        n_tokens    = r_tokens;
        n_chars     = r_chars;
        n_inside    = r_inside;
        n_text0     = r_text0;
        n_text1     = r_text1;
        n_long      = r_long;
        n_ovf       = r_ovf;
        w_chars_eff = r_inside ? r_chars : '0;
        if (i_char_valid) begin
            if (i_ch == CH_NUL) begin
                n_tokens = '0;
                n_chars  = '0;
                n_inside = 1'b0;
                n_text0  = '0;
                n_text1  = '0;
                n_long   = '0;
                n_ovf    = 1'b0;
            end else if (!r_ovf) begin
                if (w_sep) begin
                    if (r_inside) begin
                        n_tokens = r_tokens + TW'(1);
                        n_inside = 1'b0;
                        n_chars  = '0;
                    end
                end else if (!r_inside && (r_tokens >= TOK_MAX)) begin
                    n_ovf = 1'b1;
                end else begin
                    n_inside = 1'b1;
                    if (w_chars_eff >= CHR_MAX) begin
                        n_ovf = 1'b1;
                    end else begin
                        // keep text of the first two tokens only
                        if (r_tokens < TW'(2)) begin
                            if (w_chars_eff < KW_LEN) begin
                                for (int p = 0; p < KW_W / CH_W; p++) begin
                                    if (CW'(p) == w_chars_eff) begin
                                        if (r_tokens == '0) begin
                                            n_text0[p*CH_W +: CH_W] = i_ch;
                                        end else begin
                                            n_text1[p*CH_W +: CH_W] = i_ch;
                                        end
                                    end
                                end
                            end else begin
                                n_long[r_tokens[0]] = 1'b1;
                            end
                        end
                        n_chars = w_chars_eff + CW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tokens <= '0;
            r_chars  <= '0;
            r_inside <= 1'b0;
            r_text0  <= '0;
            r_text1  <= '0;
            r_long   <= '0;
            r_ovf    <= 1'b0;
        end else begin
            r_tokens <= n_tokens;
            r_chars  <= n_chars;
            r_inside <= n_inside;
            r_text0  <= n_text0;
            r_text1  <= n_text1;
            r_long   <= n_long;
            r_ovf    <= n_ovf;
        end
    end

    // close an open token at the line end
    assign w_tok_final    = r_tokens + TW'(r_inside & ~r_ovf);
    assign o_sum.tokens   = SUM_TOK_W'(w_tok_final);
    assign o_sum.overflow = r_ovf;
    assign o_sum.too_long = r_long;
    assign o_sum.text0    = r_text0;
    assign o_sum.text1    = r_text1;

endmodule

[hw/rtl/altc_matcher.sv]
`timescale 1ns / 1ps
module altc_matcher #(
    parameter int KEYWORD_CHARS     = 8,
    parameter int OPCODE_ENTRIES    = 32,
    parameter int DIRECTIVE_ENTRIES = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  altc_pkg::t_line_sum               i_sum,
    input  altc_pkg::t_kw_write               i_wr,
    input  altc_pkg::t_cfg_write              i_cfg,
    input  logic                              i_out_ready,
    output logic                              o_idle,
    output logic                              o_out_valid,
    output logic [altc_pkg::TOKCNT_W-1:0]     o_tok_total,
    output logic [2:0]                        o_line_class
);
    import altc_pkg::*;

    localparam int OAW = (OPCODE_ENTRIES > 1) ? $clog2(OPCODE_ENTRIES) : 1;
    localparam int DAW = (DIRECTIVE_ENTRIES > 1) ? $clog2(DIRECTIVE_ENTRIES) : 1;
    localparam int MAXE = (OPCODE_ENTRIES > DIRECTIVE_ENTRIES) ?
                          OPCODE_ENTRIES : DIRECTIVE_ENTRIES;
    localparam int KW = $clog2(MAXE + 1);

    logic [KW_W-1:0] op_mem  [OPCODE_ENTRIES];
    logic [KW_W-1:0] dir_mem [DIRECTIVE_ENTRIES];

    logic [OPC_COUNT_W-1:0] r_op_count;
    logic [DIR_COUNT_W-1:0] r_dir_count;

    t_mstate         r_state, n_state;
    t_line_sum       r_sum;
    logic [KW-1:0]   r_k, n_k;
    logic            r_pend, n_pend;
    logic [KW_W-1:0] r_rdata;
    logic [2:0]      r_class, n_class;
    logic            r_out_valid, n_out_valid;
    logic [TOKCNT_W-1:0] r_out_tok;
    logic [2:0]      r_out_class;

    logic [KW_W-1:0] w_kw_norm;
    logic [KW-1:0]   w_op_cnt, w_dir_cnt, w_cnt;
    logic            w_sel_op, w_tok1, w_long, w_hit, w_issue, w_load;
    logic [KW_W-1:0] w_text;

    // clear bytes from the first zero byte on and beyond the keyword length
    always_comb begin
        logic alive;
        alive     = 1'b1;
        w_kw_norm = '0;
        for (int p = 0; p < KW_W / CH_W; p++) begin
            if (i_wr.keyword[p*CH_W +: CH_W] == CH_NUL) begin
                alive = 1'b0;
            end
            if (alive && (p < KEYWORD_CHARS)) begin
                w_kw_norm[p*CH_W +: CH_W] = i_wr.keyword[p*CH_W +: CH_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr.sel == TSEL_OPCODE) && (32'(i_wr.idx) < OPCODE_ENTRIES)) begin
            op_mem[OAW'(i_wr.idx)] <= w_kw_norm;
        end
        if (i_wr.en && (i_wr.sel == TSEL_DIRECTIVE) &&
            (32'(i_wr.idx) < DIRECTIVE_ENTRIES)) begin
            dir_mem[DAW'(i_wr.idx)] <= w_kw_norm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_rdata <= w_sel_op ? op_mem[OAW'(r_k)] : dir_mem[DAW'(r_k)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_count  <= '0;
            r_dir_count <= '0;
        end else if (i_cfg.en) begin
            if (i_cfg.index == CFG_OPCODE_COUNT) begin
                r_op_count <= i_cfg.data[OPC_COUNT_W-1:0];
            end else if (i_cfg.index == CFG_DIRECTIVE_COUNT) begin
                r_dir_count <= i_cfg.data[DIR_COUNT_W-1:0];
            end
        end
    end

    assign w_op_cnt  = (32'(r_op_count) > OPCODE_ENTRIES) ? KW'(OPCODE_ENTRIES)
                                                          : KW'(r_op_count);
    assign w_dir_cnt = (32'(r_dir_count) > DIRECTIVE_ENTRIES) ? KW'(DIRECTIVE_ENTRIES)
                                                              : KW'(r_dir_count);

    assign w_sel_op = (r_state == M_OP1) || (r_state == M_OP2);
    assign w_tok1   = (r_state == M_OP2) || (r_state == M_DIR2);
    assign w_text   = w_tok1 ? r_sum.text1 : r_sum.text0;
    assign w_long   = r_sum.too_long[w_tok1];
    assign w_cnt    = w_sel_op ? w_op_cnt : w_dir_cnt;
    // shared comparator
    assign w_hit    = r_pend && (r_rdata == w_text);
    assign w_load   = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_pend      = r_pend;
        n_class     = r_class;
        n_out_valid = r_out_valid && !i_out_ready;
        w_issue     = 1'b0;
        case (r_state)
            M_IDLE: begin
                n_k    = '0;
                n_pend = 1'b0;
                if (i_start) begin
                    if (i_sum.overflow) begin
                        n_class = LC_OVERFLOW;
                        n_state = M_DONE;
                    end else if (i_sum.tokens == '0) begin
                        n_class = LC_EMPTY;
                        n_state = M_DONE;
                    end else begin
                        n_state = M_OP1;
                    end
                end
            end
            M_OP1, M_DIR1, M_OP2, M_DIR2: begin
                if (!w_long && w_hit) begin
                    n_k     = '0;
                    n_pend  = 1'b0;
                    n_state = M_DONE;
                    case (r_state)
                        M_OP1:   n_class = LC_OPCODE;
                        M_DIR1:  n_class = LC_DIRECTIVE;
                        M_OP2:   n_class = LC_LABEL_OP;
                        default: n_class = LC_LABEL_DIR;
                    endcase
                end else if (!w_long && (r_k < w_cnt)) begin
                    w_issue = 1'b1;
                    n_k     = r_k + KW'(1);
                    n_pend  = 1'b1;
                end else begin
                    // table exhausted or token too long: move to the next lookup or finish the line
                    n_k    = '0;
                    n_pend = 1'b0;
                    case (r_state)
                        M_OP1:   n_state = M_DIR1;
                        M_DIR1: begin
                            if (r_sum.tokens < SUM_TOK_W'(2)) begin
                                n_class = LC_LONE_LABEL;
                                n_state = M_DONE;
                            end else begin
                                n_state = M_OP2;
                            end
                        end
                        M_OP2:   n_state = M_DIR2;
                        default: begin
                            n_class = LC_INVALID;
                            n_state = M_DONE;
                        end
                    endcase
                end
            end
            M_DONE: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_state     = M_IDLE;
                end
            end
            default: n_state = M_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= M_IDLE;
            r_k         <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_class <= n_class;
        if (i_start) begin
            r_sum <= i_sum;
        end
        if ((r_state == M_DONE) && w_load) begin
            r_out_tok   <= r_sum.tokens[TOKCNT_W-1:0];
            r_out_class <= r_class;
        end
    end

    assign o_idle        = (r_state == M_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_tok_total   = r_out_tok;
    assign o_line_class  = r_out_class;

endmodule

[hw/rtl/altc_checker.sv]
`timescale 1ns / 1ps
module altc_checker #(
    parameter int MAX_TOKENS = 10
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_item_valid,
    input logic                              i_item_ready,
    input logic                              i_item_action,
    input logic [altc_pkg::CH_W-1:0]         i_item_ch,
    input logic                              i_res_valid,
    input logic                              i_res_ready,
    input logic [altc_pkg::TOKCNT_W-1:0]     i_res_tok_total,
    input logic [2:0]                        i_res_line_class
);
    import altc_pkg::*;

    logic w_item_acc;
    assign w_item_acc = i_item_valid && i_item_ready;

    // a stalled result holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=>
            i_res_valid && $stable(i_res_tok_total) && $stable(i_res_line_class))
        else $error("result changed while stalled");

    a_line_end_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_item_acc && (i_item_action == ACT_CHAR) && (i_item_ch == CH_NUL) |=>
            !i_item_ready)
        else $error("input ready right after a line end");

    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_item_acc && (i_item_action == ACT_WRITE) && !i_res_valid |=> !i_res_valid)
        else $error("result raised by a table write");

    a_class_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |->
            ((i_res_line_class != LC_EMPTY) || (i_res_tok_total == '0)) &&
            ((i_res_line_class != LC_LONE_LABEL) || (i_res_tok_total == 4'd1)) &&
            ((i_res_line_class != LC_LABEL_OP && i_res_line_class != LC_LABEL_DIR &&
              i_res_line_class != LC_INVALID) ||
             (i_res_tok_total >= 4'd2) || (MAX_TOKENS >= 16)))
        else $error("line class disagrees with token count");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid after reset");

endmodule

bind asm_line_token_classifier altc_checker #(
    .MAX_TOKENS (MAX_TOKENS)
) u_altc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_item_valid      (i_item.valid),
    .i_item_ready      (i_item.ready),
    .i_item_action     (i_item.action),
    .i_item_ch         (i_item.ch),
    .i_res_valid       (o_result.valid),
    .i_res_ready       (o_result.ready),
    .i_res_tok_total   (o_result.tok_total),
    .i_res_line_class  (o_result.line_class)
);

[bench/asm_line_token_classifier_tb.sv]
`timescale 1ns / 1ps
module asm_line_token_classifier_tb;
    import altc_pkg::*;

    localparam int OPC_DEPTH    = 32;
    localparam int DIR_DEPTH    = 8;
    localparam int TOK_LIMIT    = 10;
    localparam int TOK_CHARS    = 49;
    localparam int KW_CHARS     = 8;
    localparam int SETTLE       = 100;
    localparam int STALL_LIMIT  = 3000;
    localparam int IDLE_PCT     = 19;
    localparam int RANDOM_ITEMS = 480;
    localparam int PHASES       = 8;
    localparam int PLAN_ROWS    = 23;

    typedef struct {
        t_action          act;
        logic [CH_W-1:0]  ch;
        t_table_sel       sel;
        logic [IDX_W-1:0] idx;
        logic [KW_W-1:0]  kw;
    } t_stim;

    typedef struct {
        logic [TOKCNT_W-1:0] tokens;
        t_line_class         cls;
    } t_line_result;

    typedef struct {
        t_action             act;
        string               text;
        int                  reps;
        t_table_sel          sel;
        logic [IDX_W-1:0]    idx;
        logic [KW_W-1:0]     kw;
        bit                  known;
        logic [TOKCNT_W-1:0] tokens;
        t_line_class         cls;
    } t_plan_row;

    typedef logic [CH_W-1:0] t_bytes [$];

    logic i_clk;
    logic i_rst_n;

    altc_item_if   item_ch ();
    altc_cfg_if    cfg_ch ();
    altc_result_if res_ch ();

    asm_line_token_classifier dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .i_cfg    (cfg_ch),
        .o_result (res_ch)
    );

    // Shadow copy of the classifier state
    logic [KW_W-1:0] opc_kw [OPC_DEPTH];
    logic [KW_W-1:0] dir_kw [DIR_DEPTH];
    int unsigned     opc_used;
    int unsigned     dir_used;
    int unsigned     tok_done;
    int unsigned     tok_len;
    bit              in_tok;
    bit              line_ovf;
    logic [KW_W-1:0] tok_text [2];
    bit [1:0]        tok_long;

    t_line_result line_results [$];
    t_line_result no_result;
    int           errors;
    int           items_used;
    bit           steady;

    string opc_names [OPC_DEPTH] = '{
        "ADD", "AND", "NOT", "BR", "BRn", "BRz", "BRp", "BRnzp",
        "JMP", "JSR", "JSRR", "LD", "LDI", "LDR", "LEA", "ST",
        "STI", "STR", "RET", "RTI", "TRAP", "GETC", "OUT", "PUTS",
        "IN", "HALT", "MUL", "DIV", "PUSH", "POP", "MULTIPLY", "NOP"
    };
    string dir_names [DIR_DEPTH] = '{
        ".ORIG", ".FILL", ".BLKW", ".STRINGZ", ".END", ".ALIGN", ".WORD", ".GLOBAL"
    };

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [KW_W-1:0] text_kw(string s);
        logic [KW_W-1:0] kw;
        kw = '0;
        for (int p = 0; p < s.len() && p < KW_CHARS; p++) kw[8*p +: 8] = s[p];
        return kw;
    endfunction

    // Keep bytes up to the first zero, at most KW_CHARS of them
    function automatic logic [KW_W-1:0] clip_keyword(logic [KW_W-1:0] kw);
        logic [KW_W-1:0] out;
        out = '0;
        for (int p = 0; p < KW_CHARS; p++) begin
            if (kw[8*p +: 8] == 8'h00) break;
            out[8*p +: 8] = kw[8*p +: 8];
        end
        return out;
    endfunction

    function automatic bit keyword_hit(t_table_sel sel, logic [KW_W-1:0] text, bit too_long);
        if (too_long) return 1'b0;
        if (sel == TSEL_OPCODE) begin
            for (int k = 0; k < OPC_DEPTH; k++)
                if (k < opc_used && opc_kw[k] == text) return 1'b1;
        end else begin
            for (int k = 0; k < DIR_DEPTH; k++)
                if (k < dir_used && dir_kw[k] == text) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_line_class line_kind();
        if (line_ovf) return LC_OVERFLOW;
        if (tok_done == 0) return LC_EMPTY;
        if (keyword_hit(TSEL_OPCODE, tok_text[0], tok_long[0])) return LC_OPCODE;
        if (keyword_hit(TSEL_DIRECTIVE, tok_text[0], tok_long[0])) return LC_DIRECTIVE;
        if (tok_done < 2) return LC_LONE_LABEL;
        if (keyword_hit(TSEL_OPCODE, tok_text[1], tok_long[1])) return LC_LABEL_OP;
        if (keyword_hit(TSEL_DIRECTIVE, tok_text[1], tok_long[1])) return LC_LABEL_DIR;
        return LC_INVALID;
    endfunction

    function automatic void clear_line();
        tok_done    = 0;
        tok_len     = 0;
        in_tok      = 1'b0;
        line_ovf    = 1'b0;
        tok_text[0] = '0;
        tok_text[1] = '0;
        tok_long    = '0;
    endfunction

    // Advance the shadow state by one transfer; returns 1 when a line result is due
    function automatic bit track_item(t_stim s, output t_line_result r);
        r = no_result;
        if (s.act == ACT_WRITE) begin
            if (s.sel == TSEL_OPCODE) opc_kw[s.idx] = clip_keyword(s.kw);
            else if (s.idx < DIR_DEPTH) dir_kw[s.idx] = clip_keyword(s.kw);
            return 1'b0;
        end
        if (s.ch == CH_NUL) begin
            if (!line_ovf && in_tok) tok_done++;
            r.tokens = tok_done[TOKCNT_W-1:0];
            r.cls    = line_kind();
            clear_line();
            return 1'b1;
        end
        if (line_ovf) return 1'b0;
        if (s.ch == CH_SPACE || s.ch == CH_COMMA) begin
            if (in_tok) begin
                tok_done++;
                in_tok  = 1'b0;
                tok_len = 0;
            end
            return 1'b0;
        end
        if (!in_tok) begin
            if (tok_done >= TOK_LIMIT) begin
                line_ovf = 1'b1;
                return 1'b0;
            end
            in_tok  = 1'b1;
            tok_len = 0;
        end
        if (tok_len >= TOK_CHARS) begin
            line_ovf = 1'b1;
            return 1'b0;
        end
        if (tok_done < 2) begin
            if (tok_len < KW_CHARS) tok_text[tok_done][8*tok_len +: 8] = s.ch;
            else tok_long[tok_done] = 1'b1;
        end
        tok_len++;
        return 1'b0;
    endfunction

    task automatic put_item(t_stim s, bit known, t_line_result typed);
        t_line_result r;
        bit           ignored;
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.action       <= s.act;
        item_ch.ch           <= s.ch;
        item_ch.table_select <= s.sel;
        item_ch.entry_index  <= s.idx;
        item_ch.keyword      <= s.kw;
        do @(posedge i_clk); while (!item_ch.ready);
        ignored = (s.act == ACT_WRITE && s.sel == TSEL_DIRECTIVE && s.idx >= DIR_DEPTH) ||
                  (s.act == ACT_CHAR && s.ch != CH_NUL && line_ovf);
        if (!ignored) items_used++;
        if (track_item(s, r)) line_results.push_back(known ? typed : r);
    endtask

    function automatic logic [CH_W-1:0] word_char();
        logic [CH_W-1:0] c;
        do c = CH_W'($urandom_range(1, 255)); while (c == CH_SPACE || c == CH_COMMA);
        return c;
    endfunction

    function automatic logic [CH_W-1:0] sep_char();
        return $urandom_range(1) ? CH_SPACE : CH_COMMA;
    endfunction

    task automatic put_random_write();
        logic [KW_W-1:0] kw;
        t_table_sel      sel;
        logic [IDX_W-1:0] idx;
        int              n;
        kw = {$urandom, $urandom};
        if ($urandom_range(1)) begin
            n  = $urandom_range(1, KW_CHARS);
            kw = '0;
            for (int p = 0; p < n; p++) kw[8*p +: 8] = word_char();
        end
        sel = t_table_sel'($urandom_range(1));
        // aim most directive writes inside the table
        if (sel == TSEL_DIRECTIVE && $urandom_range(3) != 0)
            idx = IDX_W'($urandom_range(DIR_DEPTH - 1));
        else
            idx = IDX_W'($urandom_range(OPC_DEPTH - 1));
        put_item('{ACT_WRITE, CH_W'($urandom), sel, idx, kw}, 1'b0, no_result);
    endtask

    function automatic t_bytes make_token();
        t_bytes          w;
        logic [KW_W-1:0] kw;
        int              pick;
        int              n;
        int              k;
        pick = $urandom_range(99);
        if (pick < 55) begin
            kw = (pick < 35) ? opc_kw[$urandom_range(OPC_DEPTH - 1)]
                             : dir_kw[$urandom_range(DIR_DEPTH - 1)];
            for (int p = 0; p < KW_CHARS && kw[8*p +: 8] != 8'h00; p++) w.push_back(kw[8*p +: 8]);
            if (w.size() == 0) w.push_back(word_char());
            // flip case of one character now and then
            if (pick % 5 == 0) begin
                k = $urandom_range(w.size() - 1);
                if (w[k] != CH_SPACE) w[k] = w[k] ^ 8'h20;
            end
        end else begin
            if (pick < 85) n = $urandom_range(1, KW_CHARS);
            else if (pick < 96) n = $urandom_range(KW_CHARS + 1, 14);
            else n = $urandom_range(TOK_CHARS - 2, TOK_CHARS + 2);
            repeat (n) w.push_back(word_char());
        end
        return w;
    endfunction

    function automatic t_bytes make_line();
        t_bytes line;
        int     style;
        int     ntok;
        style = $urandom_range(99);
        if (style < 8) begin
            repeat ($urandom_range(0, 20)) line.push_back(CH_W'($urandom_range(1, 255)));
            return line;
        end
        ntok = (style < 15) ? $urandom_range(TOK_LIMIT - 1, TOK_LIMIT + 2) : $urandom_range(0, 4);
        if ($urandom_range(3) == 0) line.push_back(sep_char());
        for (int t = 0; t < ntok; t++) begin
            if (t > 0) repeat ($urandom_range(1, 3)) line.push_back(sep_char());
            line = {line, make_token()};
        end
        if ($urandom_range(3) == 0) line.push_back(sep_char());
        return line;
    endfunction

    task automatic send_line(t_bytes text, bit known, t_line_result typed, bit mixed);
        foreach (text[k]) begin
            if (mixed && $urandom_range(99) < 3) put_random_write();
            put_item('{ACT_CHAR, text[k], TSEL_OPCODE, '0, '0}, 1'b0, no_result);
        end
        put_item('{ACT_CHAR, CH_NUL, TSEL_OPCODE, '0, '0}, known, typed);
    endtask

    task automatic set_counts(int unsigned opc, int unsigned dir);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_OPCODE_COUNT;
        cfg_ch.data  <= CFG_DATA_W'(opc);
        do @(posedge i_clk); while (!cfg_ch.ready);
        opc_used = opc;
        cfg_ch.index <= CFG_DIRECTIVE_COUNT;
        cfg_ch.data  <= CFG_DATA_W'(dir);
        do @(posedge i_clk); while (!cfg_ch.ready);
        dir_used = dir;
        cfg_ch.valid <= 1'b0;
    endtask

    // Drop valid and hold until every pending line result is back
    task automatic await_results();
        item_ch.valid <= 1'b0;
        do @(posedge i_clk); while (line_results.size() != 0);
    endtask

    task automatic settle();
        await_results();
        repeat (SETTLE) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : result_check
        t_line_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (line_results.size() == 0) begin
                $error("unexpected result transfer: tok_total %0d line_class %0d",
                       res_ch.tok_total, res_ch.line_class);
                errors++;
            end else begin
                want = line_results.pop_front();
                if (res_ch.tok_total !== want.tokens) begin
                    $error("tok_total: expected %0d, actual %0d", want.tokens,
                           res_ch.tok_total);
                    errors++;
                end
                if (res_ch.line_class !== want.cls) begin
                    $error("line_class: expected %0d, actual %0d", want.cls,
                           res_ch.line_class);
                    errors++;
                end
            end
        end
        res_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    initial begin : watchdog
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((item_ch.valid && item_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
                (res_ch.valid && res_ch.ready))
                stall = 0;
            else
                stall++;
        end
        $display("asm_line_token_classifier_tb: done, errors");
        $finish;
    end

    initial begin : stimulus
        t_plan_row    plan [PLAN_ROWS];
        t_bytes       line;
        int           budget;
        int unsigned  opc_n;
        int unsigned  dir_n;
        int unsigned  opc_plan [PHASES] = '{32, 0, 1, 32, 0, 13, 32, 20};
        int unsigned  dir_plan [PHASES] = '{8, 0, 1, 0, 8, 5, 3, 8};
        bit           held;

        i_rst_n              = 1'b0;
        item_ch.valid        = 1'b0;
        item_ch.action       = ACT_CHAR;
        item_ch.ch           = CH_NUL;
        item_ch.table_select = TSEL_OPCODE;
        item_ch.entry_index  = '0;
        item_ch.keyword      = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = CFG_OPCODE_COUNT;
        cfg_ch.data          = '0;
        res_ch.ready         = 1'b0;
        no_result            = '{'0, LC_EMPTY};
        errors               = 0;
        items_used           = 0;
        steady               = 1'b0;
        opc_used             = 0;
        dir_used             = 0;
        foreach (opc_kw[k]) opc_kw[k] = '0;
        foreach (dir_kw[k]) dir_kw[k] = '0;
        clear_line();

        plan = '{
            '{ACT_CHAR, "", 1, TSEL_OPCODE, '0, '0, 1'b1, 4'd0, LC_EMPTY},
            '{ACT_CHAR, " ,, ", 1, TSEL_OPCODE, '0, '0, 1'b1, 4'd0, LC_EMPTY},
            '{ACT_CHAR, "ADD", 1, TSEL_OPCODE, '0, '0, 1'b1, 4'd1, LC_OPCODE},
            '{ACT_CHAR, ".ORIG x3000", 1, TSEL_OPCODE, '0, '0, 1'b1, 4'd2, LC_DIRECTIVE},
            '{ACT_CHAR, "LOOP ADD R1,R1,#1", 1, TSEL_OPCODE, '0, '0, 1'b1, 4'd5, LC_LABEL_OP},
            '{ACT_CHAR, "MSG .STRINGZ", 1, TSEL_OPCODE, '0, '0, 1'b1, 4'd2, LC_LABEL_DIR},
            '{ACT_CHAR, "LOOP", 1, TSEL_OPCODE, '0, '0, 1'b1, 4'd1, LC_LONE_LABEL},
            '{ACT_CHAR, "FOO,BAR", 1, TSEL_OPCODE, '0, '0, 1'b1, 4'd2, LC_INVALID},
            '{ACT_CHAR, "add", 1, TSEL_OPCODE, '0, '0, 1'b1, 4'd1, LC_LONE_LABEL},
            '{ACT_CHAR, "MULTIPLY", 1, TSEL_OPCODE, '0, '0, 1'b1, 4'd1, LC_OPCODE},
            '{ACT_CHAR, "MULTIPLYX ADD", 1, TSEL_OPCODE, '0, '0, 1'b1, 4'd2, LC_LABEL_OP},
            '{ACT_CHAR, "A ", 10, TSEL_OPCODE, '0, '0, 1'b1, 4'd10, LC_INVALID},
            '{ACT_CHAR, "A ", 11, TSEL_OPCODE, '0, '0, 1'b1, 4'd10, LC_OVERFLOW},
            '{ACT_CHAR, "B", 49, TSEL_OPCODE, '0, '0, 1'b1, 4'd1, LC_LONE_LABEL},
            '{ACT_CHAR, "B", 50, TSEL_OPCODE, '0, '0, 1'b1, 4'd0, LC_OVERFLOW},
            '{ACT_WRITE, "", 1, TSEL_OPCODE, 5'd31, '1, 1'b0, 4'd0, LC_EMPTY},
            '{ACT_CHAR, "\377", 8, TSEL_OPCODE, '0, '0, 1'b0, 4'd0, LC_EMPTY},
            '{ACT_WRITE, "", 1, TSEL_DIRECTIVE, 5'd31, '1, 1'b0, 4'd0, LC_EMPTY},
            '{ACT_WRITE, "", 1, TSEL_DIRECTIVE, 5'd7, 64'h0000_0000_5800_4441, 1'b0, 4'd0,
              LC_EMPTY},
            '{ACT_CHAR, "AD", 1, TSEL_OPCODE, '0, '0, 1'b0, 4'd0, LC_EMPTY},
            '{ACT_CHAR, "ADX AD", 1, TSEL_OPCODE, '0, '0, 1'b0, 4'd0, LC_EMPTY},
            '{ACT_CHAR, "HALT,,ADD", 1, TSEL_OPCODE, '0, '0, 1'b0, 4'd0, LC_EMPTY},
            '{ACT_CHAR, "\200\177 .END", 1, TSEL_OPCODE, '0, '0, 1'b0, 4'd0, LC_EMPTY}
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill both keyword tables before any count is raised
        foreach (opc_names[k])
            put_item('{ACT_WRITE, '0, TSEL_OPCODE, IDX_W'(k), text_kw(opc_names[k])}, 1'b0,
                     no_result);
        foreach (dir_names[k])
            put_item('{ACT_WRITE, '0, TSEL_DIRECTIVE, IDX_W'(k), text_kw(dir_names[k])}, 1'b0,
                     no_result);
        settle();
        set_counts(OPC_DEPTH, DIR_DEPTH);

        foreach (plan[i]) begin
            if (plan[i].act == ACT_WRITE) begin
                put_item('{ACT_WRITE, '0, plan[i].sel, plan[i].idx, plan[i].kw}, 1'b0, no_result);
            end else begin
                line.delete();
                repeat (plan[i].reps)
                    for (int c = 0; c < plan[i].text.len(); c++) line.push_back(plan[i].text[c]);
                send_line(line, plan[i].known, '{plan[i].tokens, plan[i].cls}, 1'b0);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            opc_n = (ph >= PHASES - 2) ? $urandom_range(OPC_DEPTH) : opc_plan[ph];
            dir_n = (ph >= PHASES - 2) ? $urandom_range(DIR_DEPTH) : dir_plan[ph];
            set_counts(opc_n, dir_n);
            steady = (ph == 4);
            budget = items_used + RANDOM_ITEMS / PHASES;
            held   = 1'b0;
            while (items_used < budget) begin
                if ($urandom_range(99) < 15) put_random_write();
                send_line(make_line(), 1'b0, no_result, 1'b1);
                if (ph == 2 && !held && items_used >= budget - RANDOM_ITEMS / (2 * PHASES)) begin
                    await_results();
                    held = 1'b1;
                end
            end
        end
        steady = 1'b0;
        settle();

        if (errors == 0 && line_results.size() == 0)
            $display("asm_line_token_classifier_tb: done, clean");
        else
            $display("asm_line_token_classifier_tb: done, errors");
        $finish;
    end

endmodule

[asm_line_token_classifier.f]
hw/rtl/altc_pkg.sv
hw/rtl/altc_if.sv
hw/rtl/altc_scanner.sv
hw/rtl/altc_matcher.sv
hw/rtl/asm_line_token_classifier.sv
hw/rtl/altc_checker.sv
bench/asm_line_token_classifier_tb.sv
